/* design/pixelate_mosaic_stream_unit_defines.svh */
// ----------------------------------------------------------------------------
// pixelate_mosaic_stream_unit_defines
// assertion macros shared by the mosaic block files
// ----------------------------------------------------------------------------
`ifndef PIXELATE_MOSAIC_STREAM_UNIT_DEFINES_SVH
`define PIXELATE_MOSAIC_STREAM_UNIT_DEFINES_SVH

// same-cycle implication
`define PMS_ASSERT(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("pms assertion failed");

// next-cycle implication
`define PMS_ASSERT_NEXT(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("pms assertion failed");

`endif

/* design/pms_pkg.sv */
// ----------------------------------------------------------------------------
// pms_pkg
// constants and types of the pixelate mosaic stream block
// ----------------------------------------------------------------------------
package pms_pkg;

	localparam int PMS_MAX_WIDTH  = 4096;
	localparam int PMS_MAX_HEIGHT = 4096;

	localparam int CFG_DIM_W   = 13;
	localparam int CFG_BLOCK_W = 8;
	localparam int PIXEL_W     = 32;
	localparam int APB_ADDR_W  = 4;
	localparam int APB_DATA_W  = 32;

	localparam logic [CFG_DIM_W-1:0]   RESET_WIDTH  = 13'd1920;
	localparam logic [CFG_DIM_W-1:0]   RESET_HEIGHT = 13'd1080;
	localparam logic [CFG_BLOCK_W-1:0] RESET_BLOCK  = 8'd10;

	localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [1:0] REG_BLOCK_SIZE   = 2'd2;

	typedef struct packed {
		logic top_left;
		logic line_end;
		logic frame_end;
	} pos_flags_t;

endpackage

/* design/pms_raster.sv */
// ----------------------------------------------------------------------------
// pms_raster
// raster position tracker: pixel, line and block phase counters, store address
// ----------------------------------------------------------------------------
`include "pixelate_mosaic_stream_unit_defines.svh"

module pms_raster
	import pms_pkg::*;
#(
	parameter int MAX_WIDTH  = PMS_MAX_WIDTH,
	parameter int MAX_HEIGHT = PMS_MAX_HEIGHT,
	localparam int AW = $clog2(MAX_WIDTH),
	localparam int HW = $clog2(MAX_HEIGHT)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   advance,
	input  logic [CFG_DIM_W-1:0]   image_width,
	input  logic [CFG_DIM_W-1:0]   image_height,
	input  logic [CFG_BLOCK_W-1:0] block_size,
	output logic [AW-1:0]          addr,
	output pos_flags_t             flags
);

	localparam int DW = $clog2(MAX_WIDTH + 1);
	localparam int DH = $clog2(MAX_HEIGHT + 1);

	logic [AW-1:0]          column_q;
	logic [HW-1:0]          row_q;
	logic [CFG_BLOCK_W-1:0] cph_q;
	logic [CFG_BLOCK_W-1:0] rph_q;
	logic [AW-1:0]          bcol_q;

	logic [DW-1:0]          w_eff;
	logic [DH-1:0]          h_eff;
	logic [CFG_BLOCK_W-1:0] bs_eff;
	logic [DW-1:0]          col_inc;
	logic [DH-1:0]          row_inc;
	logic [CFG_BLOCK_W:0]   cph_inc;
	logic [CFG_BLOCK_W:0]   rph_inc;
	logic                   cwrap;
	logic                   rwrap;

	always_comb begin
		if (image_width == '0) begin
			w_eff = DW'(1);
		end else if (32'(image_width) > MAX_WIDTH) begin
			w_eff = DW'(MAX_WIDTH);
		end else begin
			w_eff = DW'(image_width);
		end
		if (image_height == '0) begin
			h_eff = DH'(1);
		end else if (32'(image_height) > MAX_HEIGHT) begin
			h_eff = DH'(MAX_HEIGHT);
		end else begin
			h_eff = DH'(image_height);
		end
		bs_eff  = (block_size == '0) ? CFG_BLOCK_W'(1) : block_size;
		col_inc = DW'(column_q) + DW'(1);
		row_inc = DH'(row_q) + DH'(1);
		cph_inc = {1'b0, cph_q} + (CFG_BLOCK_W+1)'(1);
		rph_inc = {1'b0, rph_q} + (CFG_BLOCK_W+1)'(1);
		cwrap   = cph_inc >= {1'b0, bs_eff};
		rwrap   = rph_inc >= {1'b0, bs_eff};
	end

	assign addr            = bcol_q;
	assign flags.top_left  = (cph_q == '0) && (rph_q == '0);
	assign flags.line_end  = col_inc >= w_eff;
	assign flags.frame_end = flags.line_end && (row_inc >= h_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			row_q    <= '0;
			cph_q    <= '0;
			rph_q    <= '0;
			bcol_q   <= '0;
		end else if (advance) begin
			if (flags.line_end) begin
				column_q <= '0;
				cph_q    <= '0;
				bcol_q   <= '0;
				if (flags.frame_end) begin
					row_q <= '0;
					rph_q <= '0;
				end else begin
					row_q <= HW'(row_inc);
					rph_q <= rwrap ? '0 : CFG_BLOCK_W'(rph_inc);
				end
			end else begin
				column_q <= AW'(col_inc);
				if (cwrap) begin
					cph_q  <= '0;
					bcol_q <= bcol_q + AW'(1);
				end else begin
					cph_q  <= CFG_BLOCK_W'(cph_inc);
				end
			end
		end
	end

	`PMS_ASSERT(a_bcol_behind_col, clk, arst_n, 1'b1, bcol_q <= column_q)
	`PMS_ASSERT(a_frame_end_on_line_end, clk, arst_n, flags.frame_end, flags.line_end)
	`PMS_ASSERT_NEXT(a_frame_restart, clk, arst_n, advance && flags.frame_end,
		column_q == '0 && row_q == '0 && cph_q == '0 && rph_q == '0 && bcol_q == '0)

endmodule

/* design/pixelate_mosaic_stream_unit.sv */
// ----------------------------------------------------------------------------
// pixelate_mosaic_stream_unit
// mosaic pixelation of a raster pixel stream, one sample per block column
//
//   channel  | dir | handshake              | payload
//   pixel    | in  | pixel_valid/stall      | pixel_color
//   mosaic   | out | mosaic_valid/stall     | mosaic_color, frame_end
//   config   | in  | apb psel/penable/pready| image_width, image_height, block_size
//
// one pixel per cycle sustained while mosaic_stall is low; a request passes
// through the sample store read register and then the output register
// the sample store is not cleared, so there is no start-up pass after reset
// reset returns counters to the start of a frame and config registers to defaults
// a stalled result sits in the output register while one more request is taken
// ----------------------------------------------------------------------------
`include "pixelate_mosaic_stream_unit_defines.svh"

module pixelate_mosaic_stream_unit
	import pms_pkg::*;
#(
	parameter int MAX_WIDTH  = PMS_MAX_WIDTH,
	parameter int MAX_HEIGHT = PMS_MAX_HEIGHT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  pixel_valid,
	output logic                  pixel_stall,
	input  logic [PIXEL_W-1:0]    pixel_color,
	output logic                  mosaic_valid,
	input  logic                  mosaic_stall,
	output logic [PIXEL_W-1:0]    mosaic_color,
	output logic                  frame_end
);

	localparam int AW = $clog2(MAX_WIDTH);

	logic [CFG_DIM_W-1:0]   width_q;
	logic [CFG_DIM_W-1:0]   height_q;
	logic [CFG_BLOCK_W-1:0] block_q;

	logic [PIXEL_W-1:0] mem [MAX_WIDTH];

	logic [AW-1:0]      addr;
	pos_flags_t         flags;
	logic               accept;
	logic               load_s2;

	logic               valid_s1;
	logic [PIXEL_W-1:0] rd_s1;
	logic [PIXEL_W-1:0] pix_s1;
	logic               top_left_s1;
	logic               frame_end_s1;

	logic               valid_s2;
	logic [PIXEL_W-1:0] color_s2;
	logic               frame_end_s2;

	// configuration registers
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RESET_WIDTH;
			height_q <= RESET_HEIGHT;
			block_q  <= RESET_BLOCK;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[3:2])
				REG_IMAGE_WIDTH:  width_q  <= pwdata[CFG_DIM_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= pwdata[CFG_DIM_W-1:0];
				REG_BLOCK_SIZE:   block_q  <= pwdata[CFG_BLOCK_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(width_q);
			REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(height_q);
			REG_BLOCK_SIZE:   prdata = APB_DATA_W'(block_q);
			default:          prdata = '0;
		endcase
	end

	// handshake
	assign load_s2     = valid_s1 && (!valid_s2 || !mosaic_stall);
	assign pixel_stall = valid_s1 && !load_s2;
	assign accept      = pixel_valid && !pixel_stall;

	pms_raster #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_raster (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (accept),
		.image_width  (width_q),
		.image_height (height_q),
		.block_size   (block_q),
		.addr         (addr),
		.flags        (flags)
	);

	// sample store, one entry per block column
	always_ff @(posedge clk) begin
		if (accept) begin
			if (flags.top_left) begin
				mem[addr] <= pixel_color;
			end
			rd_s1 <= mem[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1       <= pixel_color;
			top_left_s1  <= flags.top_left;
			frame_end_s1 <= flags.frame_end;
		end
		if (load_s2) begin
			color_s2     <= top_left_s1 ? pix_s1 : rd_s1;
			frame_end_s2 <= frame_end_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (load_s2) begin
				valid_s1 <= 1'b0;
			end
			if (load_s2) begin
				valid_s2 <= 1'b1;
			end else if (!mosaic_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	assign mosaic_valid = valid_s2;
	assign mosaic_color = color_s2;
	assign frame_end    = frame_end_s2;

	`PMS_ASSERT(a_accept_moves_s1, clk, arst_n, accept && valid_s1, load_s2)
	`PMS_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, accept, valid_s1)
	`PMS_ASSERT_NEXT(a_s1_drains, clk, arst_n, valid_s1 && !valid_s2, valid_s2)

endmodule
